FILE: sv/iskl_pkg.sv
// Shared types and constants for the INI section/key lookup block.
package iskl_pkg;

   localparam int NAME_BYTES = 8;
   localparam int MAX_CAP = 256;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [2:0] REG_SECTION_NAME = 3'd0;
   localparam logic [2:0] REG_SECTION_LENGTH = 3'd1;
   localparam logic [2:0] REG_KEY_NAME = 3'd2;
   localparam logic [2:0] REG_KEY_LENGTH = 3'd3;
   localparam logic [2:0] REG_VALUE_CAP = 3'd4;

   localparam logic [8:0] VALUE_CAP_RESET = 9'd256;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] position;
      logic [7:0] value_byte;
      logic       found;
      logic [7:0] length;
   } rsp_type;

   typedef struct packed {
      logic [63:0] section_name;
      logic [3:0]  section_length;
      logic [63:0] key_name;
      logic [3:0]  key_length;
      logic [8:0]  value_cap;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

FILE: sv/iskl_scan.sv
// Line scanner: parses one text byte per transaction and produces up to two results.
module iskl_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  iskl_pkg::req_type req,
   input  iskl_pkg::cfg_type cfg,
   output iskl_pkg::push_type push
);

   typedef enum logic [6:0] {
      PH_LEAD     = 7'b0000001,
      PH_SKIP     = 7'b0000010,
      PH_HDR_LEAD = 7'b0000100,
      PH_HDR_NAME = 7'b0001000,
      PH_KEY      = 7'b0010000,
      PH_VAL_LEAD = 7'b0100000,
      PH_VAL      = 7'b1000000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       wanted_ff, wanted_in;
   logic       seen_hdr_ff, seen_hdr_in;
   logic [3:0] idx_ff, idx_in;
   logic       eq_ff, eq_in;
   logic [3:0] tlen_ff, tlen_in;
   logic       teq_ff, teq_in;
   logic [7:0] vc_ff, vc_in;
   logic [7:0] tvl_ff, tvl_in;
   logic       answered_ff, answered_in;

   logic [7:0] b;
   logic       fin;
   logic       is_blank;
   logic       is_nl;
   logic [3:0] sec_len_eff;
   logic [3:0] key_len_eff;
   logic [7:0] lim;
   logic       line_start;
   logic [3:0] base_idx;
   logic       base_eq;
   logic [3:0] base_tlen;
   logic       base_teq;
   logic [63:0] take_name;
   logic [7:0] name_byte;
   logic       same;
   logic [3:0] tk_idx;
   logic       tk_eq;
   logic [3:0] tk_tlen;
   logic       tk_teq;
   logic       key_hit;
   logic       sec_hit;
   logic       wanted_line;
   logic       vc_room;
   logic [7:0] vc_next;
   logic [7:0] tvl_next;
   logic       wr;
   logic       rep;
   logic       rep_found;
   logic [7:0] rep_len;
   iskl_pkg::rsp_type wr_item;
   iskl_pkg::rsp_type rep_item;

   assign b = req.text_byte;
   assign fin = req.final_byte;
   assign is_blank = (b == iskl_pkg::CHAR_SPACE) || (b == iskl_pkg::CHAR_TAB) ||
                     (b == iskl_pkg::CHAR_CR);
   assign is_nl = (b == iskl_pkg::CHAR_NEWLINE);

   assign sec_len_eff = (cfg.section_length > 4'(iskl_pkg::NAME_BYTES)) ?
                        4'(iskl_pkg::NAME_BYTES) : cfg.section_length;
   assign key_len_eff = (cfg.key_length > 4'(iskl_pkg::NAME_BYTES)) ?
                        4'(iskl_pkg::NAME_BYTES) : cfg.key_length;

   always_comb begin
      if (cfg.value_cap == 9'd0) begin
         lim = 8'd0;
      end else if (cfg.value_cap > 9'(iskl_pkg::MAX_CAP)) begin
         lim = 8'(iskl_pkg::MAX_CAP - 1);
      end else begin
         lim = 8'(cfg.value_cap - 9'd1);
      end
   end

   assign line_start = (phase_ff == PH_LEAD);
   assign base_idx = line_start ? 4'd0 : idx_ff;
   assign base_eq = line_start ? 1'b1 : eq_ff;
   assign base_tlen = line_start ? 4'd0 : tlen_ff;
   assign base_teq = line_start ? 1'b1 : teq_ff;

   assign take_name = ((phase_ff == PH_HDR_LEAD) || (phase_ff == PH_HDR_NAME)) ?
                      cfg.section_name : cfg.key_name;
   assign name_byte = take_name[{base_idx[2:0], 3'b000} +: 8];
   assign same = (base_idx < 4'(iskl_pkg::NAME_BYTES)) && (name_byte == b);
   assign tk_eq = base_eq && same;
   assign tk_idx = (base_idx < 4'd15) ? base_idx + 4'd1 : base_idx;
   assign tk_tlen = is_blank ? base_tlen : tk_idx;
   assign tk_teq = is_blank ? base_teq : tk_eq;

   assign key_hit = base_teq && (base_tlen == key_len_eff);
   assign sec_hit = base_teq && (base_tlen == sec_len_eff);
   assign wanted_line = seen_hdr_ff ? wanted_ff : (cfg.section_length == 4'd0);

   assign vc_room = (vc_ff < lim);
   assign vc_next = (vc_ff < 8'd255) ? vc_ff + 8'd1 : vc_ff;
   assign tvl_next = is_blank ? tvl_ff : ((vc_next < lim) ? vc_next : lim);

   always_comb begin
      phase_in = phase_ff;
      wanted_in = wanted_ff;
      seen_hdr_in = seen_hdr_ff;
      idx_in = idx_ff;
      eq_in = eq_ff;
      tlen_in = tlen_ff;
      teq_in = teq_ff;
      vc_in = vc_ff;
      tvl_in = tvl_ff;
      answered_in = answered_ff;
      wr = 1'b0;
      rep = 1'b0;
      rep_found = 1'b0;
      rep_len = 8'd0;
      if (!answered_ff) begin
         if (!is_nl) begin
            case (phase_ff)
               PH_LEAD: begin
                  if (!is_blank) begin
                     idx_in = base_idx;
                     eq_in = base_eq;
                     tlen_in = base_tlen;
                     teq_in = base_teq;
                     if ((b == iskl_pkg::CHAR_SEMI) || (b == iskl_pkg::CHAR_HASH)) begin
                        phase_in = PH_SKIP;
                     end else if (b == iskl_pkg::CHAR_LBRACKET) begin
                        phase_in = PH_HDR_LEAD;
                     end else if (!wanted_line) begin
                        phase_in = PH_SKIP;
                     end else if (b != iskl_pkg::CHAR_EQUAL) begin
                        phase_in = PH_KEY;
                        idx_in = tk_idx;
                        eq_in = tk_eq;
                        tlen_in = tk_tlen;
                        teq_in = tk_teq;
                     end else if (key_hit) begin
                        phase_in = PH_VAL_LEAD;
                        vc_in = 8'd0;
                        tvl_in = 8'd0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_HDR_LEAD, PH_HDR_NAME: begin
                  if (b == iskl_pkg::CHAR_RBRACKET) begin
                     seen_hdr_in = 1'b1;
                     wanted_in = sec_hit;
                     phase_in = PH_SKIP;
                  end else if (!(is_blank && (phase_ff == PH_HDR_LEAD))) begin
                     phase_in = PH_HDR_NAME;
                     idx_in = tk_idx;
                     eq_in = tk_eq;
                     tlen_in = tk_tlen;
                     teq_in = tk_teq;
                  end
               end
               PH_KEY: begin
                  if (b != iskl_pkg::CHAR_EQUAL) begin
                     idx_in = tk_idx;
                     eq_in = tk_eq;
                     tlen_in = tk_tlen;
                     teq_in = tk_teq;
                  end else if (key_hit) begin
                     phase_in = PH_VAL_LEAD;
                     vc_in = 8'd0;
                     tvl_in = 8'd0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_VAL_LEAD, PH_VAL: begin
                  if (!(is_blank && (phase_ff == PH_VAL_LEAD))) begin
                     phase_in = PH_VAL;
                     wr = vc_room;
                     vc_in = vc_next;
                     tvl_in = tvl_next;
                  end
               end
               default: begin
               end
            endcase
         end
         if (is_nl || fin) begin
            if ((phase_in == PH_HDR_LEAD) || (phase_in == PH_HDR_NAME)) begin
               seen_hdr_in = 1'b1;
               wanted_in = 1'b0;
            end else if ((phase_in == PH_VAL_LEAD) || (phase_in == PH_VAL)) begin
               rep = 1'b1;
               rep_found = 1'b1;
               rep_len = tvl_in;
               answered_in = 1'b1;
            end
            phase_in = PH_LEAD;
            idx_in = 4'd0;
            eq_in = 1'b1;
            tlen_in = 4'd0;
            teq_in = 1'b1;
         end
      end
      if (fin) begin
         if (!answered_in) begin
            rep = 1'b1;
         end
         phase_in = PH_LEAD;
         wanted_in = 1'b1;
         seen_hdr_in = 1'b0;
         idx_in = 4'd0;
         eq_in = 1'b1;
         tlen_in = 4'd0;
         teq_in = 1'b1;
         vc_in = 8'd0;
         tvl_in = 8'd0;
         answered_in = 1'b0;
      end
   end

   always_comb begin
      wr_item = '0;
      wr_item.kind = iskl_pkg::KIND_WRITE;
      wr_item.position = vc_ff;
      wr_item.value_byte = b;
      rep_item = '0;
      rep_item.kind = iskl_pkg::KIND_REPORT;
      rep_item.found = rep_found;
      rep_item.length = rep_len;
   end

   always_comb begin
      push.count = accept ? ({1'b0, wr} + {1'b0, rep}) : 2'd0;
      push.first = wr ? wr_item : rep_item;
      push.second = rep_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         wanted_ff <= 1'b1;
         seen_hdr_ff <= 1'b0;
         idx_ff <= 4'd0;
         eq_ff <= 1'b1;
         tlen_ff <= 4'd0;
         teq_ff <= 1'b1;
         vc_ff <= 8'd0;
         tvl_ff <= 8'd0;
         answered_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wanted_ff <= wanted_in;
         seen_hdr_ff <= seen_hdr_in;
         idx_ff <= idx_in;
         eq_ff <= eq_in;
         tlen_ff <= tlen_in;
         teq_ff <= teq_in;
         vc_ff <= vc_in;
         tvl_ff <= tvl_in;
         answered_ff <= answered_in;
      end
   end

   a_answered_idle: assert property (@(posedge clock) disable iff (reset)
      answered_ff |-> (phase_ff == PH_LEAD))
      else $error("answered scan left line start");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (push.first.kind == iskl_pkg::KIND_WRITE) &&
         (push.second.kind == iskl_pkg::KIND_REPORT))
      else $error("write and report out of order");

   a_final_reports: assert property (@(posedge clock) disable iff (reset)
      (accept && req.final_byte && !answered_ff) |-> (push.count != 2'd0))
      else $error("final byte gave no report");

   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req.final_byte) |=> (!answered_ff && (phase_ff == PH_LEAD)))
      else $error("scan state not restarted after final byte");

endmodule

FILE: sv/iskl_queue.sv
// Result queue: takes up to two results per cycle and hands out one unless rsp_stall is high.
module iskl_queue (
   input  logic               clock,
   input  logic               reset,
   input  iskl_pkg::push_type push,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output iskl_pkg::rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(iskl_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(iskl_pkg::QUEUE_DEPTH + 1);

   iskl_pkg::rsp_type entry_ff [iskl_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_next;

   assign full = (count_ff > CNT_W'(iskl_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data = entry_ff[rd_ptr_ff];
   assign pop = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push.count) - (pop ? CNT_W'(1) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(iskl_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> !full)
      else $error("push into full result queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

FILE: sv/ini_section_key_lookup.sv
// INI section/key lookup: byte stream scanner with a register port and a result queue.
// A byte's results pass through the registered result queue to rsp; one byte per cycle
// unless req_stall; each yields up to two results, drained one per cycle unless rsp_stall.
// req_stall rises while the four-entry result queue holds more than two results.
// Reset clears the scan state and the queue and sets the registers to zero, value_cap to 256.
module ini_section_key_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iskl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iskl_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [5:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   iskl_pkg::cfg_type  cfg_ff;
   iskl_pkg::push_type push;
   logic               accept;
   logic               full;
   logic               csr_write;
   logic [2:0]         reg_index;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.section_name <= '0;
         cfg_ff.section_length <= '0;
         cfg_ff.key_name <= '0;
         cfg_ff.key_length <= '0;
         cfg_ff.value_cap <= iskl_pkg::VALUE_CAP_RESET;
      end else if (csr_write) begin
         case (reg_index)
            iskl_pkg::REG_SECTION_NAME: cfg_ff.section_name <= pwdata;
            iskl_pkg::REG_SECTION_LENGTH: cfg_ff.section_length <= pwdata[3:0];
            iskl_pkg::REG_KEY_NAME: cfg_ff.key_name <= pwdata;
            iskl_pkg::REG_KEY_LENGTH: cfg_ff.key_length <= pwdata[3:0];
            iskl_pkg::REG_VALUE_CAP: cfg_ff.value_cap <= pwdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         iskl_pkg::REG_SECTION_NAME: prdata = cfg_ff.section_name;
         iskl_pkg::REG_SECTION_LENGTH: prdata = {60'd0, cfg_ff.section_length};
         iskl_pkg::REG_KEY_NAME: prdata = cfg_ff.key_name;
         iskl_pkg::REG_KEY_LENGTH: prdata = {60'd0, cfg_ff.key_length};
         iskl_pkg::REG_VALUE_CAP: prdata = {55'd0, cfg_ff.value_cap};
         default: prdata = 64'd0;
      endcase
   end

   assign req_stall = full;
   assign accept = req_valid && !req_stall;

   iskl_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .push   (push)
   );

   iskl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
